@@ src/rmq_pkg.sv @@
// Package for the rotation matrix to quaternion converter.
// Holds the item structs, component codes and pipeline control types; no dependencies.
package rmq_pkg;

	localparam int DATA_W        = 16;
	localparam int NUM_W         = DATA_W + 1;
	localparam int QBITS         = DATA_W - 1;
	localparam int FRAC_BITS_DEF = 14;

	typedef struct packed {
		logic signed [DATA_W-1:0] m00;
		logic signed [DATA_W-1:0] m01;
		logic signed [DATA_W-1:0] m02;
		logic signed [DATA_W-1:0] m10;
		logic signed [DATA_W-1:0] m11;
		logic signed [DATA_W-1:0] m12;
		logic signed [DATA_W-1:0] m20;
		logic signed [DATA_W-1:0] m21;
		logic signed [DATA_W-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] q_w;
		logic signed [DATA_W-1:0] q_x;
		logic signed [DATA_W-1:0] q_y;
		logic signed [DATA_W-1:0] q_z;
		logic                     degenerate;
	} quat_t;

	typedef enum logic [1:0] {DOM_W, DOM_X, DOM_Y, DOM_Z} dom_t;

	typedef struct packed {
		dom_t                    dom;
		logic                    degen;
		logic signed [NUM_W-1:0] n0;
		logic signed [NUM_W-1:0] n1;
		logic signed [NUM_W-1:0] n2;
	} carry_t;

	typedef struct packed {
		dom_t                     dom;
		logic                     degen;
		logic [2:0]               ovf;
		logic [2:0]               neg;
		logic signed [DATA_W-1:0] domv;
	} dv_ctl_t;

endpackage

@@ src/rmq_if.sv @@
// Valid/ready channel interfaces for matrix items and quaternion items.
// Depends on rmq_pkg for the payload structs.
interface mat_if;
	logic          valid;
	logic          ready;
	rmq_pkg::mat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface quat_if;
	logic           valid;
	logic           ready;
	rmq_pkg::quat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to unit quaternion converter, fully pipelined, one item per cycle while the output does not stall.
// Depends on rmq_pkg and the channel interfaces in rmq_if.sv.
// The block takes one matrix per cycle while the output is not stalled and passes it through
// one front stage, one stage per root bit of the square root (16 for
// FRAC_BITS = 14), one divider setup stage, 15 restoring divider stages and the output
// register. The whole pipeline stops while a result waits at the output, so a stall loses
// and repeats no item.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	mat_if.sink    mat_in,
	quat_if.source quat_out
);
	import rmq_pkg::*;

	localparam int SW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int VW = SW - 1 + FRAC_BITS;
	localparam int RW = (VW + 1) / 2;
	localparam int TW = 2 * RW + 1;
	localparam int NW = ((FRAC_BITS + NUM_W > RW) ? FRAC_BITS + NUM_W : RW) + 1;
	localparam int CW = ((NW > RW + QBITS + 1) ? NW : RW + QBITS + 1) + 1;

	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || quat_out.ready;
	assign mat_in.ready = adv;

	// Front stage: trace test, dominant axis, radicand and numerators.
	logic signed [SW-1:0] e00, e11, e22, trace, s, one_c;
	logic signed [NUM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	carry_t pay_c;
	logic [VW-1:0] v_c;

	always_comb begin
		a00 = NUM_W'(mat_in.data.m00);
		a01 = NUM_W'(mat_in.data.m01);
		a02 = NUM_W'(mat_in.data.m02);
		a10 = NUM_W'(mat_in.data.m10);
		a11 = NUM_W'(mat_in.data.m11);
		a12 = NUM_W'(mat_in.data.m12);
		a20 = NUM_W'(mat_in.data.m20);
		a21 = NUM_W'(mat_in.data.m21);
		a22 = NUM_W'(mat_in.data.m22);
		e00 = SW'(mat_in.data.m00);
		e11 = SW'(mat_in.data.m11);
		e22 = SW'(mat_in.data.m22);
		one_c = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;
		trace = e00 + e11 + e22;
		if (trace > 0) begin
			pay_c.dom = DOM_W;
			s = trace + one_c;
			pay_c.n0 = a21 - a12;
			pay_c.n1 = a02 - a20;
			pay_c.n2 = a10 - a01;
		end else if (e22 > ((e11 > e00) ? e11 : e00)) begin
			pay_c.dom = DOM_Z;
			s = e22 - e00 - e11 + one_c;
			pay_c.n0 = a10 - a01;
			pay_c.n1 = a02 + a20;
			pay_c.n2 = a12 + a21;
		end else if (e11 > e00) begin
			pay_c.dom = DOM_Y;
			s = e11 - e22 - e00 + one_c;
			pay_c.n0 = a02 - a20;
			pay_c.n1 = a21 + a12;
			pay_c.n2 = a01 + a10;
		end else begin
			pay_c.dom = DOM_X;
			s = e00 - e11 - e22 + one_c;
			pay_c.n0 = a21 - a12;
			pay_c.n1 = a10 + a01;
			pay_c.n2 = a20 + a02;
		end
		pay_c.degen = !(s > 0);
		v_c = (s > 0) ? (VW'($unsigned(s)) << FRAC_BITS) : '0;
	end

	// Square root, one result bit per stage.
	logic [TW-1:0] sq_rem_s [RW+1];
	logic [RW-1:0] sq_res_s [RW+1];
	carry_t        sq_pay_s [RW+1];
	logic          sq_vld_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq_vld_s[0] <= mat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem_s[0] <= TW'(v_c);
			sq_res_s[0] <= '0;
			sq_pay_s[0] <= pay_c;
		end
	end

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		localparam int B = RW - 1 - g;
		logic [TW-1:0] trial;
		logic          take;
		assign trial = (TW'(sq_res_s[g]) << (B + 1)) + (TW'(1) << (2 * B));
		assign take  = sq_rem_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[g+1] <= sq_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[g+1] <= take ? sq_rem_s[g] - trial : sq_rem_s[g];
				sq_res_s[g+1] <= take ? (sq_res_s[g] | (RW'(1) << B)) : sq_res_s[g];
				sq_pay_s[g+1] <= sq_pay_s[g];
			end
		end
	end

	// Divider setup: numerators, overflow test and the dominant component.
	logic [RW-1:0]    root;
	logic [CW-1:0]    den_c;
	logic [CW-1:0]    num_c [3];
	logic [2:0]       neg_c, ovf_c;
	logic [RW:0]      half_c;
	logic [NUM_W-1:0] mag_c [3];
	logic signed [NUM_W-1:0] nsel [3];

	assign root    = sq_res_s[RW];
	assign den_c   = CW'(root) << 1;
	assign nsel[0] = sq_pay_s[RW].n0;
	assign nsel[1] = sq_pay_s[RW].n1;
	assign nsel[2] = sq_pay_s[RW].n2;
	assign half_c  = ((RW+1)'(root) + (RW+1)'(1)) >> 1;

	for (genvar c = 0; c < 3; c++) begin : g_num
		assign neg_c[c] = nsel[c] < 0;
		assign mag_c[c] = neg_c[c] ? $unsigned(-nsel[c]) : $unsigned(nsel[c]);
		assign num_c[c] = (CW'(mag_c[c]) << FRAC_BITS) + CW'(root);
		assign ovf_c[c] = num_c[c] >= (den_c << QBITS);
	end

	logic [CW-1:0]    dv_rem_s [QBITS+1][3];
	logic [QBITS-1:0] dv_q_s   [QBITS+1][3];
	logic [CW-1:0]    dv_den_s [QBITS+1];
	dv_ctl_t          dv_ctl_s [QBITS+1];
	logic             dv_vld_s [QBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= sq_vld_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= num_c[c];
				dv_q_s[0][c]   <= '0;
			end
			dv_den_s[0]       <= den_c;
			dv_ctl_s[0].dom   <= sq_pay_s[RW].dom;
			dv_ctl_s[0].degen <= sq_pay_s[RW].degen;
			dv_ctl_s[0].ovf   <= ovf_c;
			dv_ctl_s[0].neg   <= neg_c;
			dv_ctl_s[0].domv  <= (half_c > (RW+1)'(32767)) ? DATA_W'(32767) : DATA_W'(half_c);
		end
	end

	// Restoring division, one quotient bit per stage, three lanes.
	for (genvar g = 0; g < QBITS; g++) begin : g_div
		localparam int B = QBITS - 1 - g;
		logic [CW-1:0] sub;
		assign sub = dv_den_s[g] << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < 3; c++) begin
					if (dv_rem_s[g][c] >= sub) begin
						dv_rem_s[g+1][c] <= dv_rem_s[g][c] - sub;
						dv_q_s[g+1][c]   <= dv_q_s[g][c] | (QBITS'(1) << B);
					end else begin
						dv_rem_s[g+1][c] <= dv_rem_s[g][c];
						dv_q_s[g+1][c]   <= dv_q_s[g][c];
					end
				end
				dv_den_s[g+1] <= dv_den_s[g];
				dv_ctl_s[g+1] <= dv_ctl_s[g];
			end
		end
	end

	// Output: signs, saturation, placement of the components and zeroing of degenerate results.
	logic signed [DATA_W-1:0] cv [3];
	dv_ctl_t                  ctl;
	quat_t                    res_c;

	assign ctl = dv_ctl_s[QBITS];

	for (genvar c = 0; c < 3; c++) begin : g_fin
		always_comb begin
			if (ctl.ovf[c]) begin
				cv[c] = ctl.neg[c] ? DATA_W'(-32768) : DATA_W'(32767);
			end else if (ctl.neg[c]) begin
				cv[c] = -$signed({1'b0, dv_q_s[QBITS][c]});
			end else begin
				cv[c] = $signed({1'b0, dv_q_s[QBITS][c]});
			end
		end
	end

	always_comb begin
		res_c.degenerate = ctl.degen;
		unique case (ctl.dom)
			DOM_W: begin
				res_c.q_w = ctl.domv; res_c.q_x = cv[0]; res_c.q_y = cv[1]; res_c.q_z = cv[2];
			end
			DOM_X: begin
				res_c.q_w = cv[0]; res_c.q_x = ctl.domv; res_c.q_y = cv[1]; res_c.q_z = cv[2];
			end
			DOM_Y: begin
				res_c.q_w = cv[0]; res_c.q_x = cv[2]; res_c.q_y = ctl.domv; res_c.q_z = cv[1];
			end
			DOM_Z: begin
				res_c.q_w = cv[0]; res_c.q_x = cv[1]; res_c.q_y = cv[2]; res_c.q_z = ctl.domv;
			end
			default: begin
				res_c.q_w = '0; res_c.q_x = '0; res_c.q_y = '0; res_c.q_z = '0;
			end
		endcase
		if (ctl.degen) begin
			res_c.q_w = '0;
			res_c.q_x = '0;
			res_c.q_y = '0;
			res_c.q_z = '0;
		end
	end

	quat_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_c;
		end
	end

	assign quat_out.valid = out_valid_q;
	assign quat_out.data  = out_q;

endmodule
